// ===== rtl/rmm_pkg.sv =====
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared types and constants of the per-channel running min, max and mean.
// ----------------------------------------------------------------------------
`default_nettype none

package rmm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 64;
    localparam int COUNT_W  = 32;
    localparam int CHAN_W   = 6;
    localparam int MODE_W   = 2;

    localparam logic [MODE_W-1:0] MODE_MAX  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MEAN = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_FULL = '1;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] max_val;
        logic signed [SAMPLE_W-1:0] min_val;
        logic signed [SUM_W-1:0]    sum;
        logic [COUNT_W-1:0]         count;
    } entry_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_PUSH
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/rmm_div.sv =====
// ----------------------------------------------------------------------------
// rmm_div
// Serial signed divider: 64-bit sum over 32-bit count, one quotient bit per
// cycle, rounded toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rmm_div
    import rmm_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic signed [SUM_W-1:0]    dividend,
    input  wire logic [COUNT_W-1:0]         divisor,
    output logic                            done,
    output logic signed [SAMPLE_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(SUM_W) + 1;

    logic [SUM_W-1:0]   dvd_reg, dvd_next;
    logic [COUNT_W:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0] dsr_reg, dsr_next;
    logic               neg_reg, neg_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [COUNT_W:0]   rem_try;
    logic [SUM_W-1:0]   q_mag;

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_try   = {rem_reg[COUNT_W-1:0], dvd_reg[SUM_W-1]};
        if (start) begin
            neg_next  = dividend[SUM_W-1];
            dvd_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_try >= {1'b0, dsr_reg}) begin
                rem_next = rem_try - {1'b0, dsr_reg};
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_try;
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign q_mag    = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;
    assign quotient = q_mag[SAMPLE_W-1:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== rtl/per_channel_running_min_max_mean.sv =====
// ----------------------------------------------------------------------------
// per_channel_running_min_max_mean
// Per-channel running maximum, minimum and mean held in one statistics memory.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)             | tuser
//  s_       | in        | channel[5:0], sample[37:6]     | clear_all
//  m_       | out       | out_channel[5:0], stat.[37:6]  | -
//  cfg_     | in        | mode in cfg_wdata[1:0]         | -
//
// A max or min request goes through read, update and push; a mean request
// adds a divide step in the one-bit-a-cycle divider before the push.
// After reset and after a clear request the memory is swept with s_tready
// low. A result waiting in the output register stalls only the push of the
// next one.
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_running_min_max_mean
    import rmm_pkg::*;
#(
    parameter int NUM_CHANNELS = 64
)(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,     // mode[1:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,       // channel[5:0], sample[37:6]
    input  wire logic        s_tuser,       // clear_all
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata        // out_channel[5:0], statistic[37:6]
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    entry_t mem [NUM_CHANNELS];

    state_t                     state_reg, state_next;
    logic [MODE_W-1:0]          mode_reg;
    logic [AW-1:0]              sweep_reg, sweep_next;
    logic [AW-1:0]              addr_reg;
    logic [CHAN_W-1:0]          chan_reg;
    logic signed [SAMPLE_W-1:0] samp_reg;
    entry_t                     rd_reg;
    logic signed [SAMPLE_W-1:0] res_reg, res_next;
    logic                       mt_valid_reg;
    logic [CHAN_W-1:0]          mt_chan_reg;
    logic signed [SAMPLE_W-1:0] mt_stat_reg;

    logic                       accept;
    logic [CHAN_W-1:0]          in_chan;
    logic [AW+CHAN_W-1:0]       chan_ext;
    logic [AW-1:0]              in_addr;
    logic                       in_range;
    entry_t                     upd;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    entry_t                     wr_data;
    logic                       div_start;
    logic                       div_done;
    logic signed [SAMPLE_W-1:0] div_q;
    logic                       push;

    assign in_chan  = s_tdata[CHAN_W-1:0];
    assign chan_ext = {{AW{1'b0}}, in_chan};
    assign in_addr  = chan_ext[AW-1:0];
    assign in_range = {26'd0, in_chan} < 32'(NUM_CHANNELS);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign push     = (state_reg == ST_PUSH) && (!mt_valid_reg || m_tready);

    // read-modify-write of one entry
    always_comb begin
        upd = rd_reg;
        if (!rd_reg.valid) begin
            upd.valid   = 1'b1;
            upd.max_val = samp_reg;
            upd.min_val = samp_reg;
            upd.sum     = SUM_W'(samp_reg);
            upd.count   = COUNT_W'(1);
        end else begin
            if (samp_reg > rd_reg.max_val) upd.max_val = samp_reg;
            if (samp_reg < rd_reg.min_val) upd.min_val = samp_reg;
            if (rd_reg.count != COUNT_FULL) begin
                upd.sum   = rd_reg.sum + SUM_W'(samp_reg);
                upd.count = rd_reg.count + 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = addr_reg;
        wr_data    = upd;
        div_start  = 1'b0;
        case (state_reg)
            ST_SWEEP: begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(NUM_CHANNELS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser) begin
                        sweep_next = '0;
                        state_next = ST_SWEEP;
                    end else if (in_range) begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                wr_en = 1'b1;
                case (mode_reg)
                    MODE_MAX: begin
                        res_next   = upd.max_val;
                        state_next = ST_PUSH;
                    end
                    MODE_MIN: begin
                        res_next   = upd.min_val;
                        state_next = ST_PUSH;
                    end
                    default: begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                endcase
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    res_next   = div_q;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            sweep_reg    <= '0;
            mode_reg     <= MODE_MAX;
            mt_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            if (cfg_we) mode_reg <= cfg_wdata[MODE_W-1:0];
            if (push) begin
                mt_valid_reg <= 1'b1;
            end else if (m_tready) begin
                mt_valid_reg <= 1'b0;
            end
        end
        res_reg <= res_next;
        if (accept) begin
            addr_reg <= in_addr;
            chan_reg <= in_chan;
            samp_reg <= s_tdata[CHAN_W+SAMPLE_W-1:CHAN_W];
        end
        if (push) begin
            mt_chan_reg <= chan_reg;
            mt_stat_reg <= res_reg;
        end
    end

    // statistics memory
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[in_addr];
    end

    rmm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (upd.sum),
        .divisor  (upd.count),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = mt_valid_reg;
    assign m_tdata  = {2'b00, mt_stat_reg, mt_chan_reg};

endmodule

`default_nettype wire
